FILE: src/mrc_pkg.sv
// Shared types, constants and step functions for the mixed-radix index converter.
package mrc_pkg;

  localparam int MAX_DIGITS     = 4;
  localparam int DIGIT_BITS     = 12;
  localparam int IDX_BITS       = 48;
  localparam int NUM_BITS       = 3;
  localparam int CFG_IDX_BITS   = 3;
  localparam int DIG_IDX_BITS   = $clog2(MAX_DIGITS);
  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES     = MAX_DIGITS * IDX_BITS / BITS_PER_STAGE;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_DIGITS = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIX_0    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIX_1    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIX_2    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIX_3    = 3'd4;

  // Operation codes
  localparam logic OP_PACK  = 1'b0;
  localparam logic OP_SPLIT = 1'b1;

  typedef logic [DIGIT_BITS-1:0] digit_t;
  typedef logic [IDX_BITS-1:0]   index_t;

  // One request as it travels down the pipeline
  typedef struct packed {
    logic                       op;
    index_t                     idx;
    index_t                     work;
    digit_t                     rem;
    logic [MAX_DIGITS-1:0][DIGIT_BITS-1:0] dout;
    index_t                     acc;
    logic                       oor;
    logic [MAX_DIGITS-1:0][DIGIT_BITS-1:0] din;
  } item_t;

  // Run four restoring long-division steps on one request
  function automatic item_t div_step(item_t it, digit_t r, logic first, logic last,
                                     logic [DIG_IDX_BITS-1:0] dig);
    item_t               o;
    logic [DIGIT_BITS:0] part;
    logic                qbit;
    o = it;
    if (first) begin
      o.rem = '0;
    end
    for (int b = 0; b < BITS_PER_STAGE; b++) begin
      part = {o.rem, o.work[IDX_BITS-1]};
      qbit = 1'b0;
      if (part >= {1'b0, r}) begin
        part = part - {1'b0, r};
        qbit = 1'b1;
      end
      o.rem  = part[DIGIT_BITS-1:0];
      o.work = {o.work[IDX_BITS-2:0], qbit};
    end
    if (last) begin
      o.dout[dig] = o.rem;
    end
    return o;
  endfunction

  // One Horner multiply-accumulate step of the pack operation
  function automatic item_t mac_step(item_t it, digit_t r, digit_t d, logic used);
    item_t                          o;
    logic [IDX_BITS+DIGIT_BITS-1:0] prod;
    o    = it;
    prod = it.acc * r;
    if (used) begin
      o.acc = prod[IDX_BITS-1:0] + {{(IDX_BITS-DIGIT_BITS){1'b0}}, d};
      if (d >= r) begin
        o.oor = 1'b1;
      end
    end
    return o;
  endfunction

endpackage

FILE: src/mixed_radix_index_converter.sv
// Mixed-radix index converter: pipelined pack and split of mixed-radix digit tuples.
//
// Input channel (in_valid/in_ready) takes one request per cycle while in_ready is
// high: in_operation 0 packs in_digit_in_0..3 into an index, 1 splits in_linear_index
// into digits. Result channel (out_valid/out_ready) returns one result per request,
// in order, with the state count (product of radices in use) and an out-of-range
// flag; throughput is one request per cycle while the output is not stalled.
// The split runs as restoring long division, four quotient bits per stage, 12 stages
// per digit and 48 stages in all; the pack is a Horner multiply-accumulate chain in
// the first three division stages.
// Configuration is to be written through cfg_we/cfg_index/cfg_data only while no
// request is in flight; the user must keep to this, the block does not enforce it.
// After a write the state count settles through cnt1_r, cnt2_r and cnt3_r. Reset
// (rst_n low, synchronous) empties the pipeline and sets one digit with every radix 1.
// When out_ready is low a finished result holds in the output register; the pipeline
// keeps filling until its last stage is occupied, then in_ready drops and every stage holds.
module mixed_radix_index_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [47:0] in_linear_index,
  input  logic [11:0] in_digit_in_0,
  input  logic [11:0] in_digit_in_1,
  input  logic [11:0] in_digit_in_2,
  input  logic [11:0] in_digit_in_3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_packed_index,
  output logic [11:0] out_digit_out_0,
  output logic [11:0] out_digit_out_1,
  output logic [11:0] out_digit_out_2,
  output logic [11:0] out_digit_out_3,
  output logic [47:0] out_state_count,
  output logic        out_of_range
);

  localparam int NST = mrc_pkg::DIV_STAGES;

  logic [mrc_pkg::NUM_BITS-1:0] num_digits_r;
  mrc_pkg::digit_t              radix_r [mrc_pkg::MAX_DIGITS];
  mrc_pkg::digit_t              radix_eff [mrc_pkg::MAX_DIGITS];
  logic [mrc_pkg::MAX_DIGITS-1:0] used;
  logic [mrc_pkg::NUM_BITS-1:0] n_eff;

  logic [2*mrc_pkg::DIGIT_BITS-1:0] cnt1_r;
  logic [3*mrc_pkg::DIGIT_BITS-1:0] cnt2_r;
  mrc_pkg::index_t                  cnt3_r;
  logic [2*mrc_pkg::DIGIT_BITS-1:0] cnt1_nxt;
  logic [3*mrc_pkg::DIGIT_BITS-1:0] cnt2_nxt;
  logic [4*mrc_pkg::DIGIT_BITS-1:0] cnt3_nxt;

  mrc_pkg::item_t st_r   [NST+1];
  mrc_pkg::item_t st_nxt [NST+1];
  logic [NST:0]   vld_r;
  logic           en;

  logic            out_valid_r;
  mrc_pkg::index_t packed_r;
  mrc_pkg::digit_t dout_r [mrc_pkg::MAX_DIGITS];
  mrc_pkg::index_t count_r;
  logic            oor_r;
  logic            oor_nxt;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_digits_r <= mrc_pkg::NUM_BITS'(1);
      for (int i = 0; i < mrc_pkg::MAX_DIGITS; i++) begin
        radix_r[i] <= mrc_pkg::DIGIT_BITS'(1);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrc_pkg::REG_NUM_DIGITS: num_digits_r <= cfg_data[mrc_pkg::NUM_BITS-1:0];
        mrc_pkg::REG_RADIX_0:    radix_r[0]   <= cfg_data;
        mrc_pkg::REG_RADIX_1:    radix_r[1]   <= cfg_data;
        mrc_pkg::REG_RADIX_2:    radix_r[2]   <= cfg_data;
        mrc_pkg::REG_RADIX_3:    radix_r[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the digit count and map unused or zero radices to one
  always_comb begin
    n_eff = num_digits_r;
    if (num_digits_r == '0) begin
      n_eff = mrc_pkg::NUM_BITS'(1);
    end else if (num_digits_r > mrc_pkg::NUM_BITS'(mrc_pkg::MAX_DIGITS)) begin
      n_eff = mrc_pkg::NUM_BITS'(mrc_pkg::MAX_DIGITS);
    end
    for (int i = 0; i < mrc_pkg::MAX_DIGITS; i++) begin
      used[i]      = mrc_pkg::NUM_BITS'(i) < n_eff;
      radix_eff[i] = (used[i] && radix_r[i] != '0) ? radix_r[i] : mrc_pkg::DIGIT_BITS'(1);
    end
  end

  // Build the state count, one multiply per register
  assign cnt1_nxt = radix_eff[0] * radix_eff[1];
  assign cnt2_nxt = cnt1_r * radix_eff[2];
  assign cnt3_nxt = cnt2_r * radix_eff[3];

  always_ff @(posedge clk) begin
    cnt1_r <= cnt1_nxt;
    cnt2_r <= cnt2_nxt;
    cnt3_r <= cnt3_nxt[mrc_pkg::IDX_BITS-1:0];
  end

  // Advance unless the last stage and the output register are both full and out_ready is low
  assign en       = !vld_r[NST] || !out_valid_r || out_ready;
  assign in_ready = en;

  // Capture a new request
  always_comb begin
    st_nxt[0]      = '0;
    st_nxt[0].op   = in_operation;
    st_nxt[0].idx  = in_linear_index;
    st_nxt[0].work = in_linear_index;
    st_nxt[0].din  = {in_digit_in_3, in_digit_in_2, in_digit_in_1, in_digit_in_0};
    st_nxt[0].acc  = {{(mrc_pkg::IDX_BITS-mrc_pkg::DIGIT_BITS){1'b0}}, in_digit_in_0};
    st_nxt[0].oor  = in_digit_in_0 >= radix_eff[0];
  end

  // Division stages, least significant digit first; Horner steps ride along early
  for (genvar k = 1; k <= NST; k++) begin : g_stage
    localparam int S    = (k - 1) * mrc_pkg::BITS_PER_STAGE;
    localparam int DIG  = mrc_pkg::MAX_DIGITS - 1 - S / mrc_pkg::IDX_BITS;
    localparam bit FST  = (S % mrc_pkg::IDX_BITS) == 0;
    localparam bit LST  = ((S + mrc_pkg::BITS_PER_STAGE) % mrc_pkg::IDX_BITS) == 0;
    mrc_pkg::item_t dv;
    always_comb begin
      dv = mrc_pkg::div_step(st_r[k-1], radix_eff[DIG], FST, LST,
                             mrc_pkg::DIG_IDX_BITS'(DIG));
      if (k < mrc_pkg::MAX_DIGITS) begin
        st_nxt[k] = mrc_pkg::mac_step(dv, radix_eff[k % mrc_pkg::MAX_DIGITS],
                                      st_r[k-1].din[k % mrc_pkg::MAX_DIGITS],
                                      used[k % mrc_pkg::MAX_DIGITS]);
      end else begin
        st_nxt[k] = dv;
      end
    end
  end

  // Shift the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= NST; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // Flag a split index at or above the state count; a pack keeps its digit flag
  assign oor_nxt = (st_r[NST].op == mrc_pkg::OP_SPLIT) ? (st_r[NST].idx >= cnt3_r)
                                                        : st_r[NST].oor;

  // Load the output register when it is free or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= vld_r[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      packed_r <= (st_r[NST].op == mrc_pkg::OP_PACK) ? st_r[NST].acc : '0;
      for (int i = 0; i < mrc_pkg::MAX_DIGITS; i++) begin
        dout_r[i] <= (st_r[NST].op == mrc_pkg::OP_SPLIT) ? st_r[NST].dout[i] : '0;
      end
      count_r <= cnt3_r;
      oor_r   <= oor_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_packed_index = packed_r;
  assign out_digit_out_0  = dout_r[0];
  assign out_digit_out_1  = dout_r[1];
  assign out_digit_out_2  = dout_r[2];
  assign out_digit_out_3  = dout_r[3];
  assign out_state_count  = count_r;
  assign out_of_range     = oor_r;

endmodule
